// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms used by the port register block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gpr_pkg.sv
// ----------------------------------------------------------------------------
// GPIO port register package
// Register indexes, access codes, lock status type and field helpers.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int PIN_COUNT_DEF = 16;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [3:0] REG_MODE   = 4'd0;
  localparam logic [3:0] REG_OTYPE  = 4'd1;
  localparam logic [3:0] REG_SPEED  = 4'd2;
  localparam logic [3:0] REG_PULL   = 4'd3;
  localparam logic [3:0] REG_INPUT  = 4'd4;
  localparam logic [3:0] REG_OUTPUT = 4'd5;
  localparam logic [3:0] REG_SETRST = 4'd6;
  localparam logic [3:0] REG_LOCK   = 4'd7;
  localparam logic [3:0] REG_AFL    = 4'd8;
  localparam logic [3:0] REG_AFH    = 4'd9;

  localparam logic [1:0] MODE_OUTPUT = 2'b01;

  typedef struct packed {
    logic        done;
    logic [15:0] pins;
  } lock_status_t;

  // Mask of implemented pins.
  function automatic logic [15:0] pin_mask_of(input int count);
    logic [15:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < count) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Widen a per-pin mask to 2-bit fields.
  function automatic logic [31:0] spread2(input logic [15:0] m);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = {2{m[i]}};
    end
    return r;
  endfunction

  // Widen an 8-pin mask to 4-bit fields.
  function automatic logic [31:0] spread4(input logic [7:0] m);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{m[i]}};
    end
    return r;
  endfunction

  // Keep frozen bits, drop bits of missing pins.
  function automatic logic [31:0] merge(input logic [31:0] old_val,
                                        input logic [31:0] data,
                                        input logic [31:0] impl,
                                        input logic [31:0] frozen);
    logic [31:0] writable;
    writable = impl & ~frozen;
    return ((old_val & ~writable) | (data & writable)) & impl;
  endfunction

endpackage

// File: design/gpr_lock.sv
// ----------------------------------------------------------------------------
// GPIO lock sequencer
// Tracks the three-write key sequence and holds the locked pin mask.
// ----------------------------------------------------------------------------
module gpr_lock #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  logic [31:0]          write_data,
  output gpr_pkg::lock_status_t status,
  output gpr_pkg::lock_status_t status_next
);
  import gpr_pkg::*;

  localparam logic [15:0] PIN_MASK = pin_mask_of(PIN_COUNT);

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_KEY0 = 2'd1;
  localparam logic [1:0] STEP_KEY1 = 2'd2;

  logic [1:0]  step;
  logic [1:0]  step_next;
  logic [15:0] seq_mask;
  logic [15:0] seq_mask_next;
  logic        key;
  logic [15:0] req_mask;
  logic        ok;

  assign key      = write_data[16];
  assign req_mask = write_data[15:0] & PIN_MASK;

  always_comb begin
    unique case (step)
      STEP_KEY0: ok = !key && (req_mask == seq_mask);
      STEP_KEY1: ok = key && (req_mask == seq_mask);
      default:   ok = 1'b0;
    endcase
  end

  always_comb begin
    step_next     = step;
    seq_mask_next = seq_mask;
    status_next   = status;
    if (wr && !status.done) begin
      priority if (ok && step == STEP_KEY0) begin
        step_next = STEP_KEY1;
      end else if (ok) begin
        status_next.done = 1'b1;
        status_next.pins = seq_mask;
        step_next        = STEP_IDLE;
      end else if (key) begin
        // restart with this request as the first key write
        step_next     = STEP_KEY0;
        seq_mask_next = req_mask;
      end else begin
        step_next     = STEP_IDLE;
        seq_mask_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= STEP_IDLE;
      seq_mask <= '0;
      status   <= '0;
    end else begin
      step     <= step_next;
      seq_mask <= seq_mask_next;
      status   <= status_next;
    end
  end

endmodule

// File: design/gpr_regfile.sv
// ----------------------------------------------------------------------------
// GPIO configuration and data registers
// Applies one bus request to the port registers and forms its read data.
// ----------------------------------------------------------------------------
module gpr_regfile #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  logic                  command,
  input  logic [3:0]            reg_index,
  input  logic [31:0]           write_data,
  input  logic [15:0]           pin_levels,
  input  gpr_pkg::lock_status_t lock_cur,
  output logic [31:0]           read_data,
  output logic [15:0]           drive_levels,
  output logic [15:0]           drive_enable
);
  import gpr_pkg::*;

  localparam logic [15:0] PIN_MASK  = pin_mask_of(PIN_COUNT);
  localparam logic [31:0] PIN_MASK2 = spread2(PIN_MASK);
  localparam logic [31:0] AFL_IMPL  = spread4(PIN_MASK[7:0]);
  localparam logic [31:0] AFH_IMPL  = spread4(PIN_MASK[15:8]);

  logic [31:0] mode;
  logic [31:0] mode_next;
  logic [15:0] otype;
  logic [15:0] otype_next;
  logic [31:0] speed;
  logic [31:0] speed_next;
  logic [31:0] pull;
  logic [31:0] pull_next;
  logic [31:0] af_low;
  logic [31:0] af_low_next;
  logic [31:0] af_high;
  logic [31:0] af_high_next;
  logic [15:0] latch;
  logic [15:0] latch_next;
  logic [15:0] frz;
  logic [31:0] frz2;

  assign frz  = lock_cur.done ? lock_cur.pins : 16'h0000;
  assign frz2 = spread2(frz);

  always_comb begin
    mode_next    = mode;
    otype_next   = otype;
    speed_next   = speed;
    pull_next    = pull;
    af_low_next  = af_low;
    af_high_next = af_high;
    latch_next   = latch;
    if (command == CMD_WRITE) begin
      unique case (reg_index)
        REG_MODE:   mode_next  = merge(mode, write_data, PIN_MASK2, frz2);
        REG_OTYPE:  otype_next = 16'(merge({16'h0000, otype}, write_data,
                                           {16'h0000, PIN_MASK}, {16'h0000, frz}));
        REG_SPEED:  speed_next = merge(speed, write_data, PIN_MASK2, frz2);
        REG_PULL:   pull_next  = merge(pull, write_data, PIN_MASK2, frz2);
        REG_OUTPUT: latch_next = write_data[15:0] & PIN_MASK;
        // set wins over clear
        REG_SETRST: latch_next = ((latch & ~write_data[31:16]) | write_data[15:0])
                                 & PIN_MASK;
        REG_AFL:    af_low_next  = merge(af_low, write_data, AFL_IMPL,
                                         spread4(frz[7:0]));
        REG_AFH:    af_high_next = merge(af_high, write_data, AFH_IMPL,
                                         spread4(frz[15:8]));
        default: ;
      endcase
    end
  end

  always_comb begin
    read_data = '0;
    if (command == CMD_READ) begin
      unique case (reg_index)
        REG_MODE:   read_data = mode;
        REG_OTYPE:  read_data = {16'h0000, otype};
        REG_SPEED:  read_data = speed;
        REG_PULL:   read_data = pull;
        REG_INPUT:  read_data = {16'h0000, pin_levels & PIN_MASK};
        REG_OUTPUT: read_data = {16'h0000, latch};
        REG_LOCK:   read_data = {15'h0000, lock_cur.done, lock_cur.pins};
        REG_AFL:    read_data = af_low;
        REG_AFH:    read_data = af_high;
        default:    read_data = '0;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      drive_enable[i] = (mode_next[2*i +: 2] == MODE_OUTPUT) && PIN_MASK[i];
    end
  end

  assign drive_levels = latch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= '0;
      otype   <= '0;
      speed   <= '0;
      pull    <= '0;
      af_low  <= '0;
      af_high <= '0;
      latch   <= '0;
    end else if (update) begin
      mode    <= mode_next;
      otype   <= otype_next;
      speed   <= speed_next;
      pull    <= pull_next;
      af_low  <= af_low_next;
      af_high <= af_high_next;
      latch   <= latch_next;
    end
  end

endmodule

// File: design/gpio_port_register_block.sv
// ----------------------------------------------------------------------------
// GPIO port register block
// Sixteen-pin port with set/reset and lock registers behind a stream port.
// ----------------------------------------------------------------------------
// Each request is one register read or write. A request is taken into an
// input register, applied to the port registers in one pass of logic, and its
// result is registered on the master side once the output register is free.
// One request is accepted every clock cycle while results are taken; the rate
// is set by the single register update pass, and a stalled result holds the
// input register until the master side is free again.
module gpio_port_register_block #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // write_data[31:0], pin_levels[47:32]
  input  logic [4:0]  s_tuser,   // command[0], reg_index[4:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[31:0], drive_levels[47:32], drive_enable[63:48],
  // lock_active[64], zero pad[71:65]
  output logic [71:0] m_tdata
);
  import gpr_pkg::*;

  logic         in_valid;
  logic         in_cmd;
  logic [3:0]   in_idx;
  logic [31:0]  in_data;
  logic [15:0]  in_pins;
  logic         advance;
  logic         lock_wr;
  logic         out_valid;
  logic [71:0]  out_data;
  logic [31:0]  rd;
  logic [15:0]  drive;
  logic [15:0]  en;
  lock_status_t lock_cur;
  lock_status_t lock_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign lock_wr  = advance && (in_cmd == CMD_WRITE) && (in_idx == REG_LOCK);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser[0];
      in_idx  <= s_tuser[4:1];
      in_data <= s_tdata[31:0];
      in_pins <= s_tdata[47:32];
    end
  end

  gpr_lock #(
    .PIN_COUNT(PIN_COUNT)
  ) u_lock (
    .clk        (clk),
    .rst        (rst),
    .wr         (lock_wr),
    .write_data (in_data),
    .status     (lock_cur),
    .status_next(lock_next)
  );

  gpr_regfile #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regfile (
    .clk         (clk),
    .rst         (rst),
    .update      (advance),
    .command     (in_cmd),
    .reg_index   (in_idx),
    .write_data  (in_data),
    .pin_levels  (in_pins),
    .lock_cur    (lock_cur),
    .read_data   (rd),
    .drive_levels(drive),
    .drive_enable(en)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {7'h00, lock_next.done, en, drive, rd};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

`include "assert_macros.svh"

  `ASSERT_NXT(a_lock_sticky, lock_cur.done, lock_cur.done, "lock released without reset")
  `ASSERT_NXT(a_lock_pins_hold, lock_cur.done, lock_cur.pins == $past(lock_cur.pins), "locked pin mask changed")
  `ASSERT_NXT(a_write_reads_zero, advance && (in_cmd == CMD_WRITE), out_data[31:0] == 32'h0, "write request returned read data")
  `ASSERT_NXT(a_result_held, out_valid && !m_tready, out_valid && $stable(out_data), "stalled result changed")

endmodule
